FILE: src/sfrt_pkg.sv
// ----------------------------------------------------------------------------
// sfrt_pkg
// Types and constants shared by the serial frame receiver with idle timeout.
// ----------------------------------------------------------------------------
package sfrt_pkg;

   localparam int MAX_FRAME_DEFAULT = 256;

   // APB register map: register index is paddr[3:2]
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_FRAME_MODE      = 2'd0;
   localparam logic [1:0] REG_TERMINATOR_BYTE = 2'd1;
   localparam logic [1:0] REG_FRAME_LENGTH    = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd3;

   localparam logic       MODE_TERMINATOR = 1'b0;
   localparam logic       MODE_LENGTH     = 1'b1;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [1:0] END_TERMINATOR = 2'd0;
   localparam logic [1:0] END_LENGTH     = 2'd1;
   localparam logic [1:0] END_TIMEOUT    = 2'd2;
   localparam logic [1:0] END_FULL       = 2'd3;

   localparam logic        RST_FRAME_MODE      = MODE_TERMINATOR;
   localparam logic [7:0]  RST_TERMINATOR_BYTE = 8'd13;
   localparam logic [8:0]  RST_FRAME_LENGTH    = 9'd16;
   localparam logic [15:0] RST_TIMEOUT_TICKS   = 16'd1000;

   typedef struct packed {
      logic        frame_mode;
      logic [7:0]  terminator_byte;
      logic [8:0]  frame_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_value;
      logic [7:0] byte_index;
      logic       frame_end;
      logic [1:0] end_status;
      logic [8:0] frame_size;
   } result_type;

endpackage

FILE: src/sfrt_frame_ctrl.sv
// ----------------------------------------------------------------------------
// sfrt_frame_ctrl
// Frame state (open flag, byte count, idle count) and the single-pass
// decision for one item: pass a byte out, end the frame, or stay silent.
// ----------------------------------------------------------------------------
module sfrt_frame_ctrl
   import sfrt_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       opcode,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       has_result,
   output result_type result
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   logic             frame_active_ff, frame_active_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]      idle_ticks_ff, idle_ticks_in;

   logic [CNT_W-1:0] count_inc;
   logic [CNT_W+8:0] cur_ext;
   logic [CNT_W+8:0] inc_ext;
   logic [CNT_W+8:0] len_ext;
   logic [15:0]      idle_inc;
   logic             len_hit;
   logic             buf_full;
   logic             timed_out;

   assign count_inc = byte_count_ff + CNT_W'(1);
   assign cur_ext   = {9'b0, byte_count_ff};
   assign inc_ext   = {9'b0, count_inc};
   assign len_ext   = {{CNT_W{1'b0}}, cfg.frame_length};
   assign len_hit   = inc_ext >= len_ext;
   assign buf_full  = count_inc >= CNT_W'(MAX_FRAME);
   // idle count saturates
   assign idle_inc  = (idle_ticks_ff == 16'hFFFF) ? idle_ticks_ff : idle_ticks_ff + 16'd1;
   assign timed_out = idle_inc >= cfg.timeout_ticks;

   always_comb begin
      has_result      = 1'b0;
      result          = '0;
      frame_active_in = frame_active_ff;
      byte_count_in   = byte_count_ff;
      idle_ticks_in   = idle_ticks_ff;
      if (opcode == OP_TICK) begin
         if (frame_active_ff) begin
            idle_ticks_in = idle_inc;
            if (timed_out) begin
               has_result        = 1'b1;
               result.frame_end  = 1'b1;
               result.end_status = END_TIMEOUT;
               result.frame_size = cur_ext[8:0];
               frame_active_in   = 1'b0;
               byte_count_in     = '0;
               idle_ticks_in     = '0;
            end
         end
      end else if (cfg.frame_mode == MODE_TERMINATOR && rx_byte == cfg.terminator_byte) begin
         // terminator is not stored; with no frame open this gives an empty frame
         has_result        = 1'b1;
         result.frame_end  = 1'b1;
         result.end_status = END_TERMINATOR;
         result.frame_size = cur_ext[8:0];
         frame_active_in   = 1'b0;
         byte_count_in     = '0;
         idle_ticks_in     = '0;
      end else begin
         has_result        = 1'b1;
         result.byte_valid = 1'b1;
         result.byte_value = rx_byte;
         result.byte_index = cur_ext[7:0];
         frame_active_in   = 1'b1;
         byte_count_in     = count_inc;
         idle_ticks_in     = '0;
         // length end takes priority over buffer full
         if ((cfg.frame_mode == MODE_LENGTH && len_hit) || buf_full) begin
            result.frame_end  = 1'b1;
            result.end_status = (cfg.frame_mode == MODE_LENGTH && len_hit) ?
                                END_LENGTH : END_FULL;
            result.frame_size = inc_ext[8:0];
            frame_active_in   = 1'b0;
            byte_count_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         byte_count_ff   <= '0;
         idle_ticks_ff   <= '0;
      end else if (step) begin
         frame_active_ff <= frame_active_in;
         byte_count_ff   <= byte_count_in;
         idle_ticks_ff   <= idle_ticks_in;
      end
   end

   a_closed_is_clear: assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> (byte_count_ff == '0 && idle_ticks_ff == '0))
      else $error("closed frame holds stale count");

   a_count_below_buffer: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < CNT_W'(MAX_FRAME))
      else $error("byte count reached buffer size without ending the frame");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (step && has_result && result.frame_end) |=> !frame_active_ff)
      else $error("frame still open after its end transfer");

   a_byte_opens: assert property (@(posedge clock) disable iff (reset)
      (step && has_result && result.byte_valid && !result.frame_end)
      |=> (frame_active_ff && idle_ticks_ff == '0))
      else $error("stored byte did not leave an open frame");

endmodule

FILE: src/serial_frame_receiver_timeout_core.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_timeout_core
// Serial frame receiver with idle timeout, APB register port.
// ----------------------------------------------------------------------------
// Takes one item (received byte or timer tick) per clock and gives at most one
// result per item; an item passes through the input register, then through the
// frame logic into the result register. req_ready stays high while the result
// register is empty or being read in the same cycle, so a full rate of one item
// per clock holds as long as rsp_ready does.
// Registers (byte address): frame_mode 0x0, terminator_byte 0x4,
// frame_length 0x8, timeout_ticks 0xC; write them only with the block idle.
module serial_frame_receiver_timeout_core
   import sfrt_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [7:0]            req_rx_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_byte_valid,
   output logic [7:0]            rsp_byte_value,
   output logic [7:0]            rsp_byte_index,
   output logic                  rsp_frame_end,
   output logic [1:0]            rsp_end_status,
   output logic [8:0]            rsp_frame_size,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   logic       in_valid_ff;
   logic       in_opcode_ff;
   logic [7:0] in_byte_ff;

   logic       out_valid_ff;
   result_type out_ff;

   logic       step;
   logic       has_result;
   result_type result;

   // ---- register port ----
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode      <= RST_FRAME_MODE;
         cfg_ff.terminator_byte <= RST_TERMINATOR_BYTE;
         cfg_ff.frame_length    <= RST_FRAME_LENGTH;
         cfg_ff.timeout_ticks   <= RST_TIMEOUT_TICKS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_MODE:      cfg_ff.frame_mode      <= pwdata[0];
            REG_TERMINATOR_BYTE: cfg_ff.terminator_byte <= pwdata[7:0];
            REG_FRAME_LENGTH:    cfg_ff.frame_length    <= pwdata[8:0];
            REG_TIMEOUT_TICKS:   cfg_ff.timeout_ticks   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_MODE:      prdata = {31'b0, cfg_ff.frame_mode};
         REG_TERMINATOR_BYTE: prdata = {24'b0, cfg_ff.terminator_byte};
         REG_FRAME_LENGTH:    prdata = {23'b0, cfg_ff.frame_length};
         REG_TIMEOUT_TICKS:   prdata = {16'b0, cfg_ff.timeout_ticks};
         default:             prdata = '0;
      endcase
   end

   // ---- pipeline: input register -> frame logic -> result register ----
   assign step      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_rx_byte;
      end
   end

   sfrt_frame_ctrl #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (in_opcode_ff),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= has_result;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_valid = out_ff.byte_valid;
   assign rsp_byte_value = out_ff.byte_value;
   assign rsp_byte_index = out_ff.byte_index;
   assign rsp_frame_end  = out_ff.frame_end;
   assign rsp_end_status = out_ff.end_status;
   assign rsp_frame_size = out_ff.frame_size;

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_opcode_ff)
                                  && $stable(in_byte_ff)))
      else $error("held item lost while result register stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input refused with empty input register");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !step)
      else $error("result register overwritten before its transfer");

endmodule

FILE: tb/sv/sfrt_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfrt_frame_checker
// Watches the request, response and register ports of the frame receiver,
// keeps its own copy of the frame state and register settings, predicts the
// response of every request transfer and compares each response transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sfrt_frame_checker
   import sfrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [7:0]            req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_byte_valid,
   input  logic [7:0]            rsp_byte_value,
   input  logic [7:0]            rsp_byte_index,
   input  logic                  rsp_frame_end,
   input  logic [1:0]            rsp_end_status,
   input  logic [8:0]            rsp_frame_size,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    outstanding,
   output int                    live_items,
   output int                    results_checked,
   output int                    frames_closed
);

   cfg_type    cfg;
   logic       frame_open;
   logic [8:0] stored_count;
   logic [15:0] idle_count;

   result_type pending_results[$];
   result_type predicted;
   result_type oldest;
   bit         produced;

   int fails = 0;
   int live = 0;
   int checked = 0;
   int closed = 0;

   function automatic void drop_frame();
      frame_open   = 1'b0;
      stored_count = '0;
      idle_count   = '0;
   endfunction

   // returns 1 when the transfer gives a response, with its fields in r
   function automatic bit frame_step(input logic op, input logic [7:0] b,
                                     output result_type r);
      logic [8:0] pos;
      r = '0;
      if (op == OP_TICK) begin
         if (!frame_open) return 1'b0;
         if (idle_count != 16'hFFFF) idle_count++;
         if (idle_count >= cfg.timeout_ticks) begin
            r.frame_end  = 1'b1;
            r.end_status = END_TIMEOUT;
            r.frame_size = stored_count;
            drop_frame();
            return 1'b1;
         end
         return 1'b0;
      end
      // terminator is never stored, even with no frame open
      if (cfg.frame_mode == MODE_TERMINATOR && b == cfg.terminator_byte) begin
         r.frame_end  = 1'b1;
         r.end_status = END_TERMINATOR;
         r.frame_size = stored_count;
         drop_frame();
         return 1'b1;
      end
      frame_open   = 1'b1;
      pos          = stored_count;
      stored_count = stored_count + 9'd1;
      idle_count   = '0;
      r.byte_valid = 1'b1;
      r.byte_value = b;
      r.byte_index = pos[7:0];
      // length wins over buffer full on the same byte
      if (cfg.frame_mode == MODE_LENGTH && stored_count >= cfg.frame_length) begin
         r.frame_end  = 1'b1;
         r.end_status = END_LENGTH;
      end else if (int'(stored_count) >= MAX_FRAME_DEFAULT) begin
         r.frame_end  = 1'b1;
         r.end_status = END_FULL;
      end
      if (r.frame_end) begin
         r.frame_size = stored_count;
         drop_frame();
      end
      return 1'b1;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         fails++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.frame_mode      = RST_FRAME_MODE;
         cfg.terminator_byte = RST_TERMINATOR_BYTE;
         cfg.frame_length    = RST_FRAME_LENGTH;
         cfg.timeout_ticks   = RST_TIMEOUT_TICKS;
         drop_frame();
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               fails++;
               $display("%0t: response transfer with nothing expected, byte %0d end %0d",
                        $time, rsp_byte_value, rsp_frame_end);
            end else begin
               oldest = pending_results.pop_front();
               compare_field("byte_valid", int'(oldest.byte_valid), int'(rsp_byte_valid));
               compare_field("byte_value", int'(oldest.byte_value), int'(rsp_byte_value));
               compare_field("byte_index", int'(oldest.byte_index), int'(rsp_byte_index));
               compare_field("frame_end", int'(oldest.frame_end), int'(rsp_frame_end));
               compare_field("end_status", int'(oldest.end_status), int'(rsp_end_status));
               compare_field("frame_size", int'(oldest.frame_size), int'(rsp_frame_size));
               checked++;
               if (oldest.frame_end) closed++;
            end
         end

         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_FRAME_MODE:      cfg.frame_mode      = pwdata[0];
               REG_TERMINATOR_BYTE: cfg.terminator_byte = pwdata[7:0];
               REG_FRAME_LENGTH:    cfg.frame_length    = pwdata[8:0];
               REG_TIMEOUT_TICKS:   cfg.timeout_ticks   = pwdata[15:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            // ticks with no frame open are dropped by the block
            if (req_opcode == OP_BYTE || frame_open) live++;
            produced = frame_step(req_opcode, req_rx_byte, predicted);
            if (produced) pending_results.push_back(predicted);
         end
      end

      fail_count      <= fails;
      outstanding     <= pending_results.size();
      live_items      <= live;
      results_checked <= checked;
      frames_closed   <= closed;
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the serial frame receiver testbench: drives request transfers,
// register writes and response back-pressure, and reports the verdict. A
// directed opening covers empty frames, timeouts, terminator and length
// endings and full buffers; random phases then sweep many register settings.
// ----------------------------------------------------------------------------
module tb;
   import sfrt_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 400;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_opcode;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_byte_valid;
   logic [7:0]            rsp_byte_value;
   logic [7:0]            rsp_byte_index;
   logic                  rsp_frame_end;
   logic [1:0]            rsp_end_status;
   logic [8:0]            rsp_frame_size;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   int fail_count;
   int outstanding;
   int live_items;
   int results_checked;
   int frames_closed;

   cfg_type cfg_now;
   int      items_sent = 0;
   int      reg_writes = 0;
   int      no_gap_left = 0;
   // count of long receiver holds asked for by the stimulus process
   int      long_holds = 0;

   always #1 clock = ~clock;

   serial_frame_receiver_timeout_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_end_status (rsp_end_status),
      .rsp_frame_size (rsp_frame_size),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   sfrt_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_end_status  (rsp_end_status),
      .rsp_frame_size  (rsp_frame_size),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .live_items      (live_items),
      .results_checked (results_checked),
      .frames_closed   (frames_closed)
   );

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic transfer_item(input logic op, input logic [7:0] b);
      int gap;
      if (no_gap_left > 0) begin
         no_gap_left--;
         gap = 0;
      end else begin
         gap = idle_len();
         if ($urandom_range(39) == 0) no_gap_left = $urandom_range(20, 80);
      end
      if (gap != 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // wait until every predicted response has been taken and the pipe is quiet
   task automatic settle();
      if (req_valid) req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_FRAME_MODE:      cfg_now.frame_mode      = value[0];
         REG_TERMINATOR_BYTE: cfg_now.terminator_byte = value[7:0];
         REG_FRAME_LENGTH:    cfg_now.frame_length    = value[8:0];
         REG_TIMEOUT_TICKS:   cfg_now.timeout_ticks   = value[15:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      settle();
      csr_write(idx, value);
   endtask

   task automatic apply_setting(input logic mode, input logic [7:0] term,
                                input logic [8:0] len, input logic [15:0] ticks);
      settle();
      csr_write(REG_FRAME_MODE, {31'd0, mode});
      csr_write(REG_TERMINATOR_BYTE, {24'd0, term});
      csr_write(REG_FRAME_LENGTH, {23'd0, len});
      csr_write(REG_TIMEOUT_TICKS, {16'd0, ticks});
   endtask

   // frames with random content, terminators, tick bursts and some noise
   task automatic run_random(input int target);
      int goal;
      int r;
      int n;
      logic [7:0] b;
      goal = live_items + target;
      while (live_items < goal) begin
         r = $urandom_range(99);
         if (r < 8) begin
            transfer_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         end else if (r < 78) begin
            b = 8'($urandom_range(255));
            if (cfg_now.frame_mode == MODE_TERMINATOR && $urandom_range(7) == 0)
               b = cfg_now.terminator_byte;
            transfer_item(OP_BYTE, b);
         end else begin
            if (cfg_now.timeout_ticks <= 16 && $urandom_range(2) == 0)
               n = cfg_now.timeout_ticks + $urandom_range(2);
            else
               n = $urandom_range(1, 4);
            repeat (n) transfer_item(OP_TICK, 8'($urandom_range(255)));
         end
      end
   endtask

   // response side: one ready decision per cycle, long hold on request
   initial begin
      int ready_left;
      int stall_left;
      int holds_seen;
      ready_left = 0;
      stall_left = 0;
      holds_seen = 0;
      rsp_ready  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_seen != long_holds) begin
            holds_seen = long_holds;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (ready_left > 0) begin
               ready_left--;
            end else begin
               ready_left = ($urandom_range(9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 5);
               stall_left = idle_len();
            end
         end
         @(posedge clock);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[serial_frame_receiver_timeout_core] ERROR");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_BYTE;
      req_rx_byte = 8'd0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = 32'd0;
      cfg_now.frame_mode      = RST_FRAME_MODE;
      cfg_now.terminator_byte = RST_TERMINATOR_BYTE;
      cfg_now.frame_length    = RST_FRAME_LENGTH;
      cfg_now.timeout_ticks   = RST_TIMEOUT_TICKS;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, tick with nothing open, empty frame
      transfer_item(OP_TICK, 8'h00);
      transfer_item(OP_BYTE, RST_TERMINATOR_BYTE);
      transfer_item(OP_BYTE, 8'h00);
      transfer_item(OP_BYTE, 8'hFF);
      transfer_item(OP_BYTE, 8'hA5);
      transfer_item(OP_BYTE, 8'h5A);
      transfer_item(OP_TICK, 8'hFF);
      transfer_item(OP_BYTE, RST_TERMINATOR_BYTE);
      // zero timeout: first tick closes the frame
      set_reg(REG_TIMEOUT_TICKS, 32'd0);
      transfer_item(OP_BYTE, 8'h80);
      transfer_item(OP_TICK, 8'h00);
      // a byte restarts the idle count
      set_reg(REG_TIMEOUT_TICKS, 32'd3);
      transfer_item(OP_BYTE, 8'h01);
      transfer_item(OP_TICK, 8'h00);
      transfer_item(OP_TICK, 8'h00);
      transfer_item(OP_BYTE, 8'h02);
      repeat (3) transfer_item(OP_TICK, 8'h00);
      set_reg(REG_TERMINATOR_BYTE, 32'd0);
      transfer_item(OP_BYTE, 8'h07);
      transfer_item(OP_BYTE, 8'h00);
      // length mode, zero length: one byte per frame, terminator is data
      set_reg(REG_FRAME_MODE, {31'd0, MODE_LENGTH});
      set_reg(REG_FRAME_LENGTH, 32'd0);
      transfer_item(OP_BYTE, 8'h33);
      transfer_item(OP_BYTE, 8'h00);
      set_reg(REG_FRAME_LENGTH, 32'd2);
      transfer_item(OP_BYTE, 8'hC3);
      transfer_item(OP_BYTE, 8'h3C);

      // length reached and buffer full on the same byte
      set_reg(REG_FRAME_LENGTH, 32'd256);
      repeat (256) transfer_item(OP_BYTE, 8'($urandom_range(255)));
      // length beyond the buffer: ends as buffer full
      set_reg(REG_FRAME_LENGTH, 32'd511);
      repeat (256) transfer_item(OP_BYTE, 8'($urandom_range(255)));
      apply_setting(MODE_TERMINATOR, 8'hFF, 9'd16, 16'hFFFF);
      transfer_item(OP_BYTE, 8'h12);
      repeat (20) transfer_item(OP_TICK, 8'h00);
      transfer_item(OP_BYTE, 8'hFF);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(MODE_TERMINATOR, 8'($urandom_range(255)), 9'd5, 16'd4);
            1: apply_setting(MODE_LENGTH, 8'd13, 9'd1, 16'd1);
            2: apply_setting(MODE_LENGTH, 8'($urandom_range(255)),
                             9'($urandom_range(2, 8)), 16'($urandom_range(2, 10)));
            3: apply_setting(MODE_TERMINATOR, 8'h0D, 9'd16, 16'd0);
            4: apply_setting(MODE_LENGTH, 8'h00, 9'd0, 16'hFFFF);
            5: apply_setting(MODE_TERMINATOR, 8'($urandom_range(255)), 9'd3,
                             16'($urandom_range(1, 12)));
            6: apply_setting(MODE_LENGTH, 8'd13, 9'($urandom_range(3, 16)),
                             RST_TIMEOUT_TICKS);
            default: apply_setting(MODE_TERMINATOR, 8'hFF, 9'd256, 16'd2);
         endcase
         if (phase == 0) begin
            // receiver stalls while the sender keeps going, so the block backs up
            long_holds++;
            no_gap_left = 80;
         end
         if (phase == 2) begin
            run_random(30);
            settle();
            run_random(35);
         end else begin
            run_random(65);
         end
      end

      settle();
      $display("Sent %0d request transfers (%0d live) under %0d register writes",
               items_sent, live_items, reg_writes);
      $display("Compared %0d response transfers, %0d frames closed",
               results_checked, frames_closed);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[serial_frame_receiver_timeout_core] OK");
      end else begin
         $display("[serial_frame_receiver_timeout_core] ERROR");
      end
      $finish;
   end

endmodule
